// ===== rtl/rsom_pkg.sv =====
// rsom_pkg: constants, codes and types shared by the ring trainer modules
// no dependencies
package rsom_pkg;

    localparam int NODES     = 256;
    localparam int REACH     = 4;
    localparam int FRAC_BITS = 16;

    localparam int NIDX_W  = $clog2(NODES);
    localparam int CNT_W   = NIDX_W + 1;
    localparam int STEP_W  = $clog2(REACH + 1);
    localparam int COORD_W = 16;
    localparam int RATE_W  = 16;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [RATE_W-1:0]  t_rate;

    // item functions
    localparam logic [2:0] FN_LOAD    = 3'd0;
    localparam logic [2:0] FN_TRAIN   = 3'd1;
    localparam logic [2:0] FN_EPOCH   = 3'd2;
    localparam logic [2:0] FN_READ    = 3'd3;
    localparam logic [2:0] FN_RESTART = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_ACTIVE = 3'd0;
    localparam logic [2:0] CFG_START  = 3'd1;
    localparam logic [2:0] CFG_DECAY  = 3'd2;
    localparam logic [2:0] CFG_NEIGH  = 3'd3;
    localparam logic [2:0] CFG_MOVEW  = 3'd4;

    localparam logic [8:0] RST_ACTIVE = 9'd64;
    localparam t_rate      RST_START  = 16'd52429;
    localparam t_rate      RST_DECAY  = 16'd52429;
    localparam t_rate      RST_NEIGH  = 16'd45875;

endpackage

// ===== rtl/ring_som_trainer_core.sv =====
// ring_som_trainer_core: ring self-organizing map trainer, top level
// uses rsom_pkg, rsom_cell and rsom_pull
//
// items enter on start while busy is low: load node, train on a city,
// end epoch, read node, restart rate. every item gives one result, shown
// for one cycle with o_result_valid; the receiver cannot stall it.
// nodes sit in a ring of NODES cells that rotates one place per cycle
// when moving; the node at the head cell is the one read or written.
// epoch, restart and unknown items need no rotation; a load or read first
// rotates the ring to the addressed node. a train item takes one rotation
// to node 0, a scan of the active nodes with a two-stage distance pipe,
// then up to 2*REACH+1 moves, each a rotation to its node plus an update
// through the product and write states, and a final rotation to the winner.
// busy stays high until the result cycle ends. reset restores the register
// defaults and the rate; node contents are undefined until loaded. the user
// must write registers on i_cfg_we only while idle, unchecked by the block.
module ring_som_trainer_core
    import rsom_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_func,
    input  logic [7:0] i_node_index,
    input  t_coord     i_coord_x,
    input  t_coord     i_coord_y,
    output logic       o_result_valid,
    output logic [2:0] o_kind,
    output logic [7:0] o_winner_index,
    output t_coord     o_out_x,
    output t_coord     o_out_y,
    output t_rate      o_out_rate,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEEK   = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_READ   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_DRAIN  = 4'd5;
    localparam logic [3:0] S_WGT    = 4'd6;
    localparam logic [3:0] S_NEXT   = 4'd7;
    localparam logic [3:0] S_MPROD  = 4'd8;
    localparam logic [3:0] S_MWRITE = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // configuration
    logic [8:0] r_active;
    t_rate      r_start_rate, r_decay, r_neigh;
    logic       r_move_winner;

    logic [3:0]        r_state, r_after;
    logic [NIDX_W-1:0] r_head, r_target, r_win;
    logic [CNT_W-1:0]  r_n, r_off;
    logic [STEP_W-1:0] r_step;
    logic              r_side;
    t_rate             r_rate, r_w;
    t_coord            r_cx, r_cy;
    logic [2:0]        r_kind;
    logic [7:0]        r_win_out;
    t_coord            r_ox, r_oy;

    // scan pipe
    logic              r_va;
    logic [NIDX_W-1:0] r_vidx;
    logic [31:0]       r_sqx, r_sqy;
    logic [32:0]       r_best;

    t_coord cell_x [NODES];
    t_coord cell_y [NODES];
    t_coord head_x, head_y, wr_x, wr_y, pull_x, pull_y;
    logic   shift, wr_sel;
    t_rate  move_w;

    logic signed [COORD_W:0]      dx, dy;
    logic signed [2*COORD_W+1:0]  sq_x, sq_y;
    logic [32:0]                  sq_dist;
    logic [2*RATE_W-1:0]          decay_prod, neigh_prod;
    logic [CNT_W:0]               right_sum, left_sum;
    logic [NIDX_W-1:0]            right_idx, left_idx;
    logic [CNT_W-1:0]             off_inc, n_next;

    assign head_x = cell_x[0];
    assign head_y = cell_y[0];

    assign wr_sel = (r_state == S_LOAD) || (r_state == S_MWRITE);
    assign wr_x   = (r_state == S_LOAD) ? r_cx : pull_x;
    assign wr_y   = (r_state == S_LOAD) ? r_cy : pull_y;
    assign shift  = ((r_state == S_SEEK) && (r_head != r_target)) ||
                    (r_state == S_SCAN) || wr_sel;

    genvar g;
    generate
        for (g = 0; g < NODES; g++) begin : g_ring
            t_coord in_x, in_y;
            if (g == NODES - 1) begin : g_last
                assign in_x = wr_sel ? wr_x : cell_x[0];
                assign in_y = wr_sel ? wr_y : cell_y[0];
            end else begin : g_mid
                assign in_x = cell_x[g+1];
                assign in_y = cell_y[g+1];
            end
            rsom_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_x     (in_x),
                .i_y     (in_y),
                .o_x     (cell_x[g]),
                .o_y     (cell_y[g])
            );
        end
    endgenerate

    assign move_w = (r_step == '0) ? r_rate : r_w;

    rsom_pull u_pull_x (
        .i_clk (i_clk),
        .i_p   (head_x),
        .i_c   (r_cx),
        .i_w   (move_w),
        .o_np  (pull_x)
    );

    rsom_pull u_pull_y (
        .i_clk (i_clk),
        .i_p   (head_y),
        .i_c   (r_cy),
        .i_w   (move_w),
        .o_np  (pull_y)
    );

    assign dx      = $signed({1'b0, head_x}) - $signed({1'b0, r_cx});
    assign dy      = $signed({1'b0, head_y}) - $signed({1'b0, r_cy});
    assign sq_x    = dx * dx;
    assign sq_y    = dy * dy;
    assign sq_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    assign decay_prod = r_rate * r_decay;
    assign neigh_prod = r_w * r_neigh;

    // ring neighbours: offsets stay below n, so one subtract wraps
    assign right_sum = {2'b0, r_win} + {1'b0, r_off};
    assign left_sum  = {2'b0, r_win} + {1'b0, r_n} - {1'b0, r_off};
    assign right_idx = (right_sum >= {1'b0, r_n}) ? NIDX_W'(right_sum - {1'b0, r_n})
                                                  : NIDX_W'(right_sum);
    assign left_idx  = (left_sum >= {1'b0, r_n}) ? NIDX_W'(left_sum - {1'b0, r_n})
                                                 : NIDX_W'(left_sum);
    assign off_inc   = r_off + 1'b1;

    always_comb begin
        if (r_active == '0) begin
            n_next = CNT_W'(1);
        end else if (32'(r_active) > NODES) begin
            n_next = CNT_W'(NODES);
        end else begin
            n_next = CNT_W'(r_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= RST_ACTIVE;
            r_start_rate  <= RST_START;
            r_decay       <= RST_DECAY;
            r_neigh       <= RST_NEIGH;
            r_move_winner <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE: r_active      <= i_cfg_data[8:0];
                CFG_START:  r_start_rate  <= i_cfg_data;
                CFG_DECAY:  r_decay       <= i_cfg_data;
                CFG_NEIGH:  r_neigh       <= i_cfg_data;
                CFG_MOVEW:  r_move_winner <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_va   <= (r_state == S_SCAN);
        r_vidx <= r_head;
        r_sqx  <= sq_x[31:0];
        r_sqy  <= sq_y[31:0];
        if (r_va && ((r_vidx == '0) || (sq_dist < r_best))) begin
            r_best <= sq_dist;
            r_win  <= r_vidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_rate  <= RST_START;
        end else begin
            if (shift) begin
                r_head <= (32'(r_head) == NODES - 1) ? '0 : r_head + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind    <= i_func;
                        r_win_out <= '0;
                        r_ox      <= '0;
                        r_oy      <= '0;
                        r_cx      <= i_coord_x;
                        r_cy      <= i_coord_y;
                        r_n       <= n_next;
                        r_target  <= NIDX_W'(i_node_index);
                        r_state   <= S_DONE;
                        case (i_func)
                            FN_LOAD: begin
                                if (32'(i_node_index) < NODES) begin
                                    r_after <= S_LOAD;
                                    r_state <= S_SEEK;
                                end
                            end
                            FN_READ: begin
                                if (32'(i_node_index) < NODES) begin
                                    r_after <= S_READ;
                                    r_state <= S_SEEK;
                                end
                            end
                            FN_TRAIN: begin
                                r_target <= '0;
                                r_after  <= S_SCAN;
                                r_state  <= S_SEEK;
                            end
                            FN_EPOCH:   r_rate <= decay_prod[FRAC_BITS +: RATE_W];
                            FN_RESTART: r_rate <= r_start_rate;
                            default: ;
                        endcase
                    end
                end
                S_SEEK: begin
                    if (r_head == r_target) begin
                        r_state <= r_after;
                    end
                end
                S_LOAD: r_state <= S_DONE;
                S_READ: begin
                    r_ox    <= head_x;
                    r_oy    <= head_y;
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if ({1'b0, r_head} == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the last distance to leave the pipe
                    if (!r_va) begin
                        r_step  <= '0;
                        r_side  <= 1'b0;
                        r_off   <= '0;
                        r_w     <= r_rate;
                        r_state <= S_WGT;
                    end
                end
                S_WGT: begin
                    r_after <= S_MPROD;
                    if (r_step == '0) begin
                        r_target <= r_win;
                        r_state  <= r_move_winner ? S_SEEK : S_NEXT;
                    end else begin
                        r_target <= r_side ? left_idx : right_idx;
                        r_state  <= S_SEEK;
                    end
                end
                S_NEXT: begin
                    r_step  <= r_step + 1'b1;
                    r_side  <= 1'b0;
                    r_w     <= neigh_prod[FRAC_BITS +: RATE_W];
                    r_off   <= (off_inc == r_n) ? '0 : off_inc;
                    r_state <= S_WGT;
                end
                S_MPROD: r_state <= S_MWRITE;
                S_MWRITE: begin
                    if (r_step == '0) begin
                        r_state <= S_NEXT;
                    end else if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_WGT;
                    end else if (32'(r_step) == REACH) begin
                        r_win_out <= 8'(r_win);
                        r_target  <= r_win;
                        r_after   <= S_READ;
                        r_state   <= S_SEEK;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);
    assign o_kind         = r_kind;
    assign o_winner_index = r_win_out;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_out_rate     = r_rate;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result held longer than one cycle");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> {1'b0, r_head} < r_n)
        else $error("scan beyond active ring");
    a_write_after_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MWRITE |-> $past(r_state) == S_MPROD)
        else $error("node write without product stage");
`endif

endmodule

// ===== rtl/rsom_cell.sv =====
// rsom_cell: one node of the rotating ring, holds x and y
// depends on rsom_pkg
module rsom_cell
    import rsom_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_coord i_x,
    input  t_coord i_y,
    output t_coord o_x,
    output t_coord o_y
);

    t_coord r_x;
    t_coord r_y;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== rtl/rsom_pull.sv =====
// rsom_pull: moves one coordinate toward a target, p + floor(w*(c-p)), clamped
// product registered, result formed the next cycle; depends on rsom_pkg
module rsom_pull
    import rsom_pkg::*;
(
    input  logic   i_clk,
    input  t_coord i_p,
    input  t_coord i_c,
    input  t_rate  i_w,
    output t_coord o_np
);

    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] r_prod;
    logic signed [2*COORD_W+2:0] delta;
    logic signed [2*COORD_W+2:0] np;

    assign diff = $signed({1'b0, i_c}) - $signed({1'b0, i_p});

    always_ff @(posedge i_clk) begin
        r_prod <= diff * $signed({1'b0, i_w});
    end

    // arithmetic shift gives the floor
    assign delta = (2*COORD_W+3)'(r_prod >>> FRAC_BITS);
    assign np    = $signed({{(COORD_W+3){1'b0}}, i_p}) + delta;

    always_comb begin
        if (np < 0) begin
            o_np = '0;
        end else if (np > $signed({{(COORD_W+3){1'b0}}, {COORD_W{1'b1}}})) begin
            o_np = {COORD_W{1'b1}};
        end else begin
            o_np = np[COORD_W-1:0];
        end
    end

endmodule

// ===== verif/ring_som_trainer_core_test.sv =====
// ring_som_trainer_core_test: self-checking bench for the ring trainer core
// depends on rsom_pkg and ring_som_trainer_core; a built-in predictor checks every result
`timescale 1ns / 100ps

module ring_som_trainer_core_test
    import rsom_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 110;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] idx;
        t_coord     x;
        t_coord     y;
    } t_node_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] win;
        t_coord     x;
        t_coord     y;
        t_rate      rate;
    } t_node_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] i_func = '0;
    logic [7:0] i_node_index = '0;
    t_coord     i_coord_x = '0;
    t_coord     i_coord_y = '0;
    logic       o_result_valid;
    logic [2:0] o_kind;
    logic [7:0] o_winner_index;
    t_coord     o_out_x;
    t_coord     o_out_y;
    t_rate      o_out_rate;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    ring_som_trainer_core DUT (.*);

    always #10 i_clk = ~i_clk;

    // shadow copy of the ring and the registers
    t_coord     ring_x [NODES];
    t_coord     ring_y [NODES];
    t_rate      rate_now;
    logic [8:0] reg_active;
    t_rate      reg_start;
    t_rate      reg_decay;
    t_rate      reg_neigh;
    logic       reg_movew;

    t_node_cmd  pending_q[$];
    t_node_res  expected_q[$];
    t_node_cmd  driven_item;
    int         idle_pct = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    function automatic t_coord pull_coord(t_coord p, t_coord c, int unsigned w);
        longint diff;
        longint np;
        diff = longint'(c) - longint'(p);
        np = longint'(p) + ((diff * longint'(w)) >>> FRAC_BITS);
        if (np < 0) np = 0;
        if (np > 65535) np = 65535;
        return t_coord'(np);
    endfunction

    function automatic void move_ring_node(int unsigned k, t_coord cx, t_coord cy,
                                           int unsigned w);
        ring_x[k] = pull_coord(ring_x[k], cx, w);
        ring_y[k] = pull_coord(ring_y[k], cy, w);
    endfunction

    // applies one item to the shadow ring and returns the result it should give
    function automatic t_node_res predict_node_result(t_node_cmd c);
        t_node_res   r;
        int unsigned n;
        int unsigned w;
        int unsigned off;
        longint      dx;
        longint      dy;
        longint      d;
        longint      best;
        r = '0;
        r.kind = c.func;
        case (c.func)
            FN_LOAD: begin
                ring_x[c.idx] = c.x;
                ring_y[c.idx] = c.y;
            end
            FN_TRAIN: begin
                n = (reg_active == 0) ? 1 : (reg_active > NODES) ? NODES : reg_active;
                best = 0;
                for (int unsigned k = 0; k < n; k++) begin
                    dx = longint'(ring_x[k]) - longint'(c.x);
                    dy = longint'(ring_y[k]) - longint'(c.y);
                    d = dx * dx + dy * dy;
                    if (k == 0 || d < best) begin
                        best = d;
                        r.win = k[7:0];
                    end
                end
                if (reg_movew) move_ring_node(r.win, c.x, c.y, rate_now);
                w = rate_now;
                for (int unsigned k = 1; k <= REACH; k++) begin
                    off = k % n;
                    w = int'((longint'(w) * longint'(reg_neigh)) >> FRAC_BITS);
                    move_ring_node((r.win + off) % n, c.x, c.y, w);
                    move_ring_node((r.win + n - off) % n, c.x, c.y, w);
                end
                r.x = ring_x[r.win];
                r.y = ring_y[r.win];
            end
            FN_EPOCH: rate_now = t_rate'((longint'(rate_now) * longint'(reg_decay)) >> FRAC_BITS);
            FN_READ: begin
                r.x = ring_x[c.idx];
                r.y = ring_y[c.idx];
            end
            FN_RESTART: rate_now = reg_start;
            default: ;
        endcase
        r.rate = rate_now;
        return r;
    endfunction

    // driver: start holds until the item is taken while busy is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                expected_q.insert(expected_q.size(), predict_node_result(driven_item));
            if (!start || !busy) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    driven_item  <= pending_q[0];
                    i_func       <= pending_q[0].func;
                    i_node_index <= pending_q[0].idx;
                    i_coord_x    <= pending_q[0].x;
                    i_coord_y    <= pending_q[0].y;
                    void'(pending_q.pop_front());
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results cannot be held off, so every strobe is checked
    always @(posedge i_clk) begin
        t_node_res want;
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result kind=%0d win=%0d x=%0d y=%0d rate=%0d",
                             o_kind, o_winner_index, o_out_x, o_out_y, o_out_rate);
            end else begin
                want = expected_q.pop_front();
                if (o_kind !== want.kind || o_winner_index !== want.win ||
                    o_out_x !== want.x || o_out_y !== want.y || o_out_rate !== want.rate) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp kind=%0d win=%0d x=%0d y=%0d rate=%0d,",
                                  " got kind=%0d win=%0d x=%0d y=%0d rate=%0d"},
                                 want.kind, want.win, want.x, want.y, want.rate,
                                 o_kind, o_winner_index, o_out_x, o_out_y, o_out_rate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ring_som_trainer_core_test failed");
            $finish;
        end
    end

    task automatic add_item(logic [2:0] f, logic [7:0] k, t_coord x, t_coord y);
        t_node_cmd c;
        c.func = f;
        c.idx  = k;
        c.x    = x;
        c.y    = y;
        pending_q.insert(pending_q.size(), c);
    endtask

    task automatic wait_all_done();
        while (pending_q.size() != 0 || start || busy || expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] k, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= k;
        i_cfg_data  <= v;
        case (k)
            CFG_ACTIVE: reg_active = v[8:0];
            CFG_START:  reg_start  = v;
            CFG_DECAY:  reg_decay  = v;
            CFG_NEIGH:  reg_neigh  = v;
            CFG_MOVEW:  reg_movew  = v[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return t_coord'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] act_set   [RANDOM_PHASES] = '{1, 256, 0, 300, 5, 17};
        logic [15:0] start_set [RANDOM_PHASES] = '{65535, 0, 52429, 1, 40000, 30000};
        logic [15:0] decay_set [RANDOM_PHASES] = '{65535, 0, 60000, 32768, 1, 52429};
        logic [15:0] neigh_set [RANDOM_PHASES] = '{0, 65535, 45875, 1, 32768, 60000};
        int          pct_set [4] = '{0, 46, 0, 29};
        int unsigned r;
        reg_active = RST_ACTIVE;
        reg_start  = RST_START;
        reg_decay  = RST_DECAY;
        reg_neigh  = RST_NEIGH;
        reg_movew  = 1'b0;
        rate_now   = RST_START;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole ring first so no item touches an unwritten node
        for (int k = 0; k < NODES; k++)
            add_item(FN_LOAD, k[7:0], t_coord'($urandom), t_coord'($urandom));
        wait_all_done();

        // directed: extremes, every function, a distance tie, unknown functions
        add_item(FN_LOAD, 8'd255, '1, '1);
        add_item(FN_LOAD, 8'd0, '0, '0);
        add_item(FN_READ, 8'd255, '0, '0);
        add_item(FN_READ, 8'd0, '1, '1);
        add_item(FN_TRAIN, 8'd0, '0, '0);
        add_item(FN_TRAIN, 8'd0, '1, '1);
        add_item(FN_LOAD, 8'd3, 16'd1000, 16'd1000);
        add_item(FN_LOAD, 8'd2, 16'd1000, 16'd1000);
        add_item(FN_TRAIN, 8'hff, 16'd1000, 16'd1000);
        add_item(FN_EPOCH, 8'd0, '0, '0);
        add_item(FN_EPOCH, 8'd0, '0, '0);
        add_item(FN_RESTART, 8'd0, '0, '0);
        add_item(3'd5, 8'hff, '1, '1);
        add_item(3'd6, 8'd0, '0, '0);
        add_item(3'd7, 8'h55, 16'haaaa, 16'h5555);
        add_item(FN_READ, 8'd2, '0, '0);
        wait_all_done();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(CFG_ACTIVE, act_set[p]);
            write_reg(CFG_START, start_set[p]);
            write_reg(CFG_DECAY, decay_set[p]);
            write_reg(CFG_NEIGH, neigh_set[p]);
            write_reg(CFG_MOVEW, 16'(p % 2));
            idle_pct = pct_set[p % 4];
            add_item(FN_RESTART, 8'd0, '0, '0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 20)
                    add_item(FN_TRAIN, 8'($urandom), pick_coord(), pick_coord());
                else if (r < 50)
                    add_item(FN_LOAD, 8'($urandom), pick_coord(), pick_coord());
                else if (r < 80)
                    add_item(FN_READ, 8'($urandom), 16'($urandom), 16'($urandom));
                else if (r < 88)
                    add_item(FN_EPOCH, 8'($urandom), 16'($urandom), 16'($urandom));
                else if (r < 93)
                    add_item(FN_RESTART, 8'($urandom), 16'($urandom), 16'($urandom));
                else
                    add_item(3'($urandom_range(7, 5)), 8'($urandom), 16'($urandom),
                             16'($urandom));
            end
            wait_all_done();
        end

        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("ring_som_trainer_core_test passed");
        else
            $display("ring_som_trainer_core_test failed");
        $finish;
    end

endmodule
